// File: hw/rtl/pnta_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pnta_pkg;

	localparam int NAME_SLOTS = 256;
	localparam int PORT_SLOTS = 512;

	localparam int NAME_W   = $clog2(NAME_SLOTS);
	localparam int PORT_W   = $clog2(PORT_SLOTS);
	localparam int RIGHTS_W = 3;
	localparam int ENTRY_W  = PORT_W + RIGHTS_W;

	localparam int CHUNK_W = (NAME_SLOTS >= 64) ? 32 : NAME_SLOTS / 2;
	localparam int NCHUNK  = NAME_SLOTS / CHUNK_W;
	localparam int CIDX_W  = $clog2(NCHUNK);
	localparam int CBIT_W  = $clog2(CHUNK_W);
	localparam int STEP_W  = $clog2(NCHUNK + 1);

	localparam int ROW_W  = (PORT_SLOTS >= 64) ? 32 : PORT_SLOTS / 2;
	localparam int NROWS  = PORT_SLOTS / ROW_W;
	localparam int RIDX_W = $clog2(NROWS);
	localparam int BIT_W  = $clog2(ROW_W);

	typedef enum logic [1:0] {
		OP_ALLOC  = 2'd0,
		OP_BIND   = 2'd1,
		OP_LOOKUP = 2'd2,
		OP_FREE   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK         = 2'd0,
		STAT_INVALID    = 2'd1,
		STAT_NO_NAME    = 2'd2,
		STAT_POOL_EMPTY = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ALLOC,
		ST_SCAN,
		ST_NAME_RD,
		ST_PORT_RD,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic              scan;
		logic              clr;
		logic [NAME_W-1:0] name;
	} name_req_t;

	typedef struct packed {
		logic              done;
		logic              found;
		logic [NAME_W-1:0] name;
	} name_rsp_t;

	typedef struct packed {
		logic              rd;
		logic [RIDX_W-1:0] rd_row;
		logic              wr;
		logic [RIDX_W-1:0] wr_row;
		logic [ROW_W-1:0]  wr_word;
	} pool_req_t;

endpackage

`default_nettype wire

// File: hw/rtl/pnta_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module pnta_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 12
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/pnta_name_map.sv
`timescale 1ns / 1ps
`default_nettype none

module pnta_name_map import pnta_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire name_req_t         req,
	input  wire logic [NAME_W-1:0] lk_name,
	output logic                   lk_valid,
	output name_rsp_t              rsp
);

	logic [NAME_SLOTS-1:0] valid_q;
	logic [NAME_W-1:0]     hint_q;
	logic                  busy_q;
	logic [STEP_W-1:0]     step_q;
	logic [CIDX_W-1:0]     chunk_q;
	logic [CBIT_W-1:0]     lo_q;

	logic [NAME_W-1:0]  start;
	logic [CHUNK_W-1:0] bits;
	logic [CHUNK_W-1:0] mask;
	logic [CHUNK_W-1:0] free;
	logic [CBIT_W-1:0]  idx;
	logic               found;
	logic               last;
	logic [NAME_W-1:0]  hit_name;

	assign lk_valid = valid_q[lk_name];
	assign start    = (hint_q == '0) ? NAME_W'(1) : hint_q;
	assign bits     = valid_q[{chunk_q, CBIT_W'(0)} +: CHUNK_W];
	assign last     = (step_q == STEP_W'(NCHUNK));

	always_comb begin
		for (int j = 0; j < CHUNK_W; j++) begin
			if (step_q == '0) begin
				mask[j] = (CBIT_W'(j) >= lo_q);
			end else if (last) begin
				mask[j] = (CBIT_W'(j) < lo_q);
			end else begin
				mask[j] = 1'b1;
			end
		end
		if (chunk_q == '0) begin
			mask[0] = 1'b0;
		end
	end

	assign free  = ~bits & mask;
	assign found = |free;

	always_comb begin
		idx = '0;
		for (int j = CHUNK_W - 1; j >= 0; j--) begin
			if (free[j]) begin
				idx = CBIT_W'(j);
			end
		end
	end

	assign hit_name  = {chunk_q, idx};
	assign rsp.done  = busy_q && (found || last);
	assign rsp.found = busy_q && found;
	assign rsp.name  = hit_name;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			hint_q  <= NAME_W'(1);
			busy_q  <= 1'b0;
			step_q  <= '0;
			chunk_q <= '0;
			lo_q    <= '0;
		end else begin
			if (req.clr) begin
				valid_q[req.name] <= 1'b0;
			end
			if (req.scan) begin
				busy_q  <= 1'b1;
				step_q  <= '0;
				chunk_q <= start[NAME_W-1:CBIT_W];
				lo_q    <= start[CBIT_W-1:0];
			end else if (busy_q) begin
				if (found) begin
					valid_q[hit_name] <= 1'b1;
					hint_q            <= hit_name + NAME_W'(1);
					busy_q            <= 1'b0;
				end else if (last) begin
					busy_q <= 1'b0;
				end else begin
					step_q  <= step_q + STEP_W'(1);
					chunk_q <= (chunk_q == CIDX_W'(NCHUNK - 1)) ? '0 : chunk_q + CIDX_W'(1);
				end
			end
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/pnta_port_pool.sv
`timescale 1ns / 1ps
`default_nettype none

module pnta_port_pool import pnta_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire pool_req_t         req,
	output logic [ROW_W-1:0]       rd_word,
	output logic                   full,
	output logic [RIDX_W-1:0]      free_row
);

	logic [NROWS-1:0] row_valid_q;
	logic [NROWS-1:0] row_full_q;
	logic             rd_ok_q;
	logic [ROW_W-1:0] ram_rdata;

	pnta_ram #(
		.DEPTH(NROWS),
		.WIDTH(ROW_W)
	) u_rows (
		.clk  (clk),
		.we   (req.wr),
		.waddr(req.wr_row),
		.wdata(req.wr_word),
		.re   (req.rd),
		.raddr(req.rd_row),
		.rdata(ram_rdata)
	);

	assign rd_word = rd_ok_q ? ram_rdata : '0;
	assign full    = &row_full_q;

	always_comb begin
		free_row = '0;
		for (int r = NROWS - 1; r >= 0; r--) begin
			if (!row_full_q[r]) begin
				free_row = RIDX_W'(r);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			row_full_q  <= '0;
			rd_ok_q     <= 1'b0;
		end else begin
			if (req.rd) begin
				rd_ok_q <= row_valid_q[req.rd_row];
			end
			if (req.wr) begin
				row_valid_q[req.wr_row] <= 1'b1;
				row_full_q[req.wr_row]  <= &req.wr_word;
			end
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/port_name_table_allocator.sv
`timescale 1ns / 1ps
`default_nettype none

// Port name table allocator: one request is processed at a time and yields exactly one
// response. Allocate takes the lowest free port and binds it to a name found by a next-fit
// scan from a rotating hint; bind does the same for a given port; lookup and free work on
// one name. An error goes straight to the done state; lookup and free read the name store
// and then the port row; bind runs the name scan, and allocate reads the free row before
// the scan, which checks one 32-name chunk of the valid bits per cycle. Port slots are
// tracked as 32-bit rows in a small memory with per-row full flags, so the first free
// port costs one row read. The response register lets the next request be accepted while
// a result is still waiting; a request that finishes while the previous result is still
// held waits in the done state until that transfer happens.
module port_name_table_allocator import pnta_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output logic             req_ready,
	input  wire logic [1:0]  op,
	input  wire logic [15:0] port_name,
	input  wire logic [8:0]  port_slot,
	input  wire logic [2:0]  rights,
	output logic             rsp_valid,
	input  wire logic        rsp_ready,
	output logic [1:0]       status,
	output logic [7:0]       granted_name,
	output logic [8:0]       found_port,
	output logic [2:0]       found_rights
);

	state_t state_q, state_d;

	op_t                 op_q, op_d;
	logic [PORT_W-1:0]   port_q, port_d;
	logic [RIGHTS_W-1:0] rights_q, rights_d;
	logic [ROW_W-1:0]    word_q, word_d;
	status_t             status_q, status_d;
	logic [7:0]          granted_q, granted_d;
	logic [8:0]          fport_q, fport_d;
	logic [2:0]          frights_q, frights_d;

	logic                rsp_valid_q;
	status_t             rsp_status_q;
	logic [7:0]          rsp_granted_q;
	logic [8:0]          rsp_port_q;
	logic [2:0]          rsp_rights_q;
	logic                rsp_load;

	name_req_t           name_req;
	name_rsp_t           name_rsp;
	logic [NAME_W-1:0]   lk_name;
	logic                lk_valid;
	logic                nm_ok;
	logic                slot_ok;

	pool_req_t           pool_req;
	logic [ROW_W-1:0]    pool_rd_word;
	logic                pool_full;
	logic [RIDX_W-1:0]   free_row;
	logic [BIT_W-1:0]    zero_idx;

	logic                nram_we;
	logic                nram_re;
	logic [ENTRY_W-1:0]  nram_rdata;
	logic [PORT_W-1:0]   entry_port;

	assign lk_name    = port_name[NAME_W-1:0];
	assign nm_ok      = (port_name != '0) && (int'(port_name) < NAME_SLOTS) && lk_valid;
	assign slot_ok    = (int'(port_slot) < PORT_SLOTS);
	assign entry_port = nram_rdata[ENTRY_W-1:RIGHTS_W];
	assign req_ready  = (state_q == ST_IDLE);

	pnta_name_map u_name_map (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (name_req),
		.lk_name (lk_name),
		.lk_valid(lk_valid),
		.rsp     (name_rsp)
	);

	pnta_ram #(
		.DEPTH(NAME_SLOTS),
		.WIDTH(ENTRY_W)
	) u_name_store (
		.clk  (clk),
		.we   (nram_we),
		.waddr(name_rsp.name),
		.wdata({port_q, rights_q}),
		.re   (nram_re),
		.raddr(lk_name),
		.rdata(nram_rdata)
	);

	pnta_port_pool u_port_pool (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (pool_req),
		.rd_word (pool_rd_word),
		.full    (pool_full),
		.free_row(free_row)
	);

	always_comb begin
		zero_idx = '0;
		for (int j = ROW_W - 1; j >= 0; j--) begin
			if (!pool_rd_word[j]) begin
				zero_idx = BIT_W'(j);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		op_d      = op_q;
		port_d    = port_q;
		rights_d  = rights_q;
		word_d    = word_q;
		status_d  = status_q;
		granted_d = granted_q;
		fport_d   = fport_q;
		frights_d = frights_q;
		name_req  = '0;
		pool_req  = '0;
		nram_we   = 1'b0;
		nram_re   = 1'b0;
		rsp_load  = 1'b0;
		name_req.name = lk_name;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					op_d      = op_t'(op);
					rights_d  = rights;
					status_d  = STAT_OK;
					granted_d = '0;
					fport_d   = '0;
					frights_d = '0;
					case (op_t'(op))
						OP_ALLOC: begin
							if (pool_full) begin
								status_d = STAT_POOL_EMPTY;
								state_d  = ST_DONE;
							end else begin
								port_d          = {free_row, BIT_W'(0)};
								pool_req.rd     = 1'b1;
								pool_req.rd_row = free_row;
								state_d         = ST_ALLOC;
							end
						end
						OP_BIND: begin
							if (!slot_ok) begin
								status_d = STAT_INVALID;
								state_d  = ST_DONE;
							end else begin
								port_d        = PORT_W'(port_slot);
								name_req.scan = 1'b1;
								state_d       = ST_SCAN;
							end
						end
						OP_LOOKUP, OP_FREE: begin
							if (!nm_ok) begin
								status_d = STAT_INVALID;
								state_d  = ST_DONE;
							end else begin
								nram_re      = 1'b1;
								name_req.clr = (op_t'(op) == OP_FREE);
								state_d      = ST_NAME_RD;
							end
						end
						default: begin
							status_d = STAT_INVALID;
							state_d  = ST_DONE;
						end
					endcase
				end
			end
			ST_ALLOC: begin
				word_d                = pool_rd_word;
				port_d[BIT_W-1:0]     = zero_idx;
				name_req.scan         = 1'b1;
				state_d               = ST_SCAN;
			end
			ST_SCAN: begin
				if (name_rsp.done) begin
					if (name_rsp.found) begin
						nram_we   = 1'b1;
						granted_d = 8'(name_rsp.name);
						if (op_q == OP_ALLOC) begin
							fport_d          = 9'(port_q);
							pool_req.wr      = 1'b1;
							pool_req.wr_row  = port_q[PORT_W-1:BIT_W];
							pool_req.wr_word = word_q | (ROW_W'(1) << port_q[BIT_W-1:0]);
						end
					end else begin
						status_d = STAT_NO_NAME;
					end
					state_d = ST_DONE;
				end
			end
			ST_NAME_RD: begin
				port_d          = entry_port;
				frights_d       = nram_rdata[RIGHTS_W-1:0];
				pool_req.rd     = 1'b1;
				pool_req.rd_row = entry_port[PORT_W-1:BIT_W];
				state_d         = ST_PORT_RD;
			end
			ST_PORT_RD: begin
				if (op_q == OP_LOOKUP) begin
					if (pool_rd_word[port_q[BIT_W-1:0]]) begin
						fport_d = 9'(port_q);
					end else begin
						status_d  = STAT_INVALID;
						frights_d = '0;
					end
				end else begin
					frights_d        = '0;
					pool_req.wr      = 1'b1;
					pool_req.wr_row  = port_q[PORT_W-1:BIT_W];
					pool_req.wr_word = pool_rd_word & ~(ROW_W'(1) << port_q[BIT_W-1:0]);
				end
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!rsp_valid_q || rsp_ready) begin
					rsp_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		op_q      <= op_d;
		port_q    <= port_d;
		rights_q  <= rights_d;
		word_q    <= word_d;
		status_q  <= status_d;
		granted_q <= granted_d;
		fport_q   <= fport_d;
		frights_q <= frights_d;
		if (rsp_load) begin
			rsp_status_q  <= status_q;
			rsp_granted_q <= granted_q;
			rsp_port_q    <= fport_q;
			rsp_rights_q  <= frights_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign status       = rsp_status_q;
	assign granted_name = rsp_granted_q;
	assign found_port   = rsp_port_q;
	assign found_rights = rsp_rights_q;

	// A name handed out by the scan is never the reserved name zero.
	a_scan_skips_zero: assert property (@(posedge clk) disable iff (!arst_n)
		name_rsp.done && name_rsp.found |-> name_rsp.name != '0)
		else $error("name scan granted name zero");

	// The row chosen for an allocation always has a free port in it.
	a_alloc_row_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ALLOC |-> !(&pool_rd_word))
		else $error("allocation read a full port row");

	// A new response appears only after the request has finished.
	a_rsp_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q) == ST_DONE)
		else $error("response raised outside the done state");

	// A name scan finishes only in the scan state, so no request is taken while it runs.
	a_no_accept_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		name_rsp.done |-> state_q == ST_SCAN)
		else $error("name scan finished outside the scan state");

endmodule

`default_nettype wire

// File: tb/tb_port_name_table_allocator.sv
`timescale 1ns / 1ps

module tb_port_name_table_allocator;
	import pnta_pkg::*;

	typedef struct packed {
		status_t    status;
		logic [7:0] name;
		logic [8:0] port;
		logic [2:0] rts;
	} reply_t;

	typedef struct packed {
		op_t         code;
		logic [15:0] name;
		logic [8:0]  slot;
		logic [2:0]  rts;
		logic        typed;
		reply_t      want;
	} plan_row_t;

	localparam int RUN_LIMIT    = 500000;
	localparam int RANDOM_ITEMS = 1450;
	localparam int FILL_ITEMS   = 350;
	localparam int DRAIN_CYCLES = 20;
	localparam int MAX_REPORTS  = 10;

	localparam int MODE_FILL  = 0;
	localparam int MODE_DRAIN = 1;
	localparam int MODE_MIX   = 2;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_ready;
	logic [1:0]  op = 2'd0;
	logic [15:0] port_name = 16'd0;
	logic [8:0]  port_slot = 9'd0;
	logic [2:0]  rights = 3'd0;
	logic        rsp_valid;
	logic        rsp_ready = 1'b0;
	logic [1:0]  status;
	logic [7:0]  granted_name;
	logic [8:0]  found_port;
	logic [2:0]  found_rights;

	logic       name_bound [NAME_SLOTS];
	logic [8:0] bound_port [NAME_SLOTS];
	logic [2:0] bound_rts  [NAME_SLOTS];
	logic       port_busy  [PORT_SLOTS];
	logic [7:0] port_refs  [PORT_SLOTS];
	int         next_hint;

	reply_t    replies_due [$];
	plan_row_t plan [$];
	int        fault_count = 0;
	int        sent_count;
	logic      req_steady = 1'b0;
	logic      rsp_steady = 1'b0;

	port_name_table_allocator dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (RUN_LIMIT) @(posedge clk);
		$display("[port_name_table_allocator] ERROR");
		$finish;
	end

	function automatic void clear_model();
		for (int i = 0; i < NAME_SLOTS; i++) begin
			name_bound[i] = 1'b0;
			bound_port[i] = '0;
			bound_rts[i]  = '0;
		end
		for (int i = 0; i < PORT_SLOTS; i++) begin
			port_busy[i] = 1'b0;
			port_refs[i] = '0;
		end
		next_hint = 1;
	endfunction

	function automatic void release_ref(int p);
		if (p >= PORT_SLOTS)
			return;
		if (port_refs[p] > 0)
			port_refs[p]--;
		if (port_refs[p] == 0)
			port_busy[p] = 1'b0;
	endfunction

	// Next-fit scan over names 1 to NAME_SLOTS-1; returns 0 when the table is full.
	function automatic int claim_name(int p, logic [2:0] rts);
		int start;
		int nm;
		start = (next_hint == 0 || next_hint >= NAME_SLOTS) ? 1 : next_hint;
		for (int k = 0; k < NAME_SLOTS - 1; k++) begin
			nm = 1 + ((start - 1 + k) % (NAME_SLOTS - 1));
			if (!name_bound[nm]) begin
				name_bound[nm] = 1'b1;
				bound_port[nm] = p[8:0];
				bound_rts[nm]  = rts;
				next_hint = (nm + 1) % NAME_SLOTS;
				return nm;
			end
		end
		return 0;
	endfunction

	function automatic reply_t predict_reply(op_t code, logic [15:0] name,
			logic [8:0] slot, logic [2:0] rts);
		reply_t r;
		int p;
		int g;
		r = '0;
		r.status = STAT_OK;
		case (code)
		OP_ALLOC: begin
			p = 0;
			while (p < PORT_SLOTS && port_busy[p])
				p++;
			if (p >= PORT_SLOTS) begin
				r.status = STAT_POOL_EMPTY;
			end else begin
				port_busy[p] = 1'b1;
				port_refs[p] = 8'd1;
				g = claim_name(p, rts);
				if (g == 0) begin
					release_ref(p);
					r.status = STAT_NO_NAME;
				end else begin
					r.name = g[7:0];
					r.port = p[8:0];
				end
			end
		end
		OP_BIND: begin
			if (int'(slot) >= PORT_SLOTS) begin
				r.status = STAT_INVALID;
			end else begin
				g = claim_name(int'(slot), rts);
				if (g == 0)
					r.status = STAT_NO_NAME;
				else
					r.name = g[7:0];
			end
		end
		default: begin
			if (name == 0 || int'(name) >= NAME_SLOTS || !name_bound[name]) begin
				r.status = STAT_INVALID;
			end else begin
				p = bound_port[name];
				if (code == OP_LOOKUP) begin
					if (p >= PORT_SLOTS || !port_busy[p]) begin
						r.status = STAT_INVALID;
					end else begin
						r.port = p[8:0];
						r.rts  = bound_rts[name];
					end
				end else begin
					name_bound[name] = 1'b0;
					bound_port[name] = '0;
					bound_rts[name]  = '0;
					release_ref(p);
				end
			end
		end
		endcase
		return r;
	endfunction

	function automatic logic [15:0] bound_name_near(int start);
		int nm;
		for (int k = 0; k < NAME_SLOTS; k++) begin
			nm = (start + k) % NAME_SLOTS;
			if (nm != 0 && name_bound[nm])
				return nm[15:0];
		end
		return start[15:0];
	endfunction

	task automatic add_row(op_t code, int name, int slot, int rts, logic typed,
			status_t st, int gn, int fp, int fr);
		plan_row_t row;
		row.code        = code;
		row.name        = name[15:0];
		row.slot        = slot[8:0];
		row.rts         = rts[2:0];
		row.typed       = typed;
		row.want.status = st;
		row.want.name   = gn[7:0];
		row.want.port   = fp[8:0];
		row.want.rts    = fr[2:0];
		plan.push_back(row);
	endtask

	task automatic send_item(op_t code, logic [15:0] name, logic [8:0] slot,
			logic [2:0] rts, logic typed, reply_t want);
		int gap;
		reply_t model_r;
		gap = req_steady ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		op        <= code;
		port_name <= name;
		port_slot <= slot;
		rights    <= rts;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		model_r = predict_reply(code, name, slot, rts);
		replies_due.push_back(typed ? want : model_r);
		if ($urandom_range(0, 19) == 0)
			req_steady = !req_steady;
	endtask

	task automatic random_item(int mode);
		int roll;
		op_t code;
		logic [15:0] name;
		logic [8:0] slot;
		logic [2:0] rts;
		roll = $urandom_range(0, 99);
		name = 16'($urandom_range(0, 65535));
		slot = ($urandom_range(0, 1) == 1) ? 9'($urandom_range(0, 15))
			: 9'($urandom_range(0, 511));
		rts = 3'($urandom_range(0, 7));
		case (mode)
		MODE_FILL:
			code = roll < 50 ? OP_ALLOC : roll < 85 ? OP_BIND : roll < 95 ? OP_LOOKUP : OP_FREE;
		MODE_DRAIN:
			code = roll < 60 ? OP_FREE : roll < 80 ? OP_LOOKUP : roll < 90 ? OP_ALLOC : OP_BIND;
		default:
			code = op_t'(roll % 4);
		endcase
		if ((code == OP_LOOKUP || code == OP_FREE) && $urandom_range(0, 9) < 8)
			name = bound_name_near($urandom_range(1, NAME_SLOTS - 1));
		send_item(code, name, slot, rts, 1'b0, '0);
		sent_count++;
	endtask

	initial begin
		forever begin
			int stall;
			stall = rsp_steady ? 0 : $urandom_range(0, 10);
			if (stall > 0) begin
				rsp_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			@(posedge clk);
			while (!rsp_valid) @(posedge clk);
			if ($urandom_range(0, 19) == 0)
				rsp_steady = !rsp_steady;
		end
	end

	always @(posedge clk) begin : check_replies
		reply_t got;
		reply_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			got.status = status_t'(status);
			got.name   = granted_name;
			got.port   = found_port;
			got.rts    = found_rights;
			if (replies_due.size() == 0) begin
				fault_count++;
				if (fault_count <= MAX_REPORTS)
					$display("Unexpected transfer: status %0d name %0d port %0d rights %0d",
						got.status, got.name, got.port, got.rts);
			end else begin
				want = replies_due.pop_front();
				if (got.status !== want.status || got.name !== want.name
						|| got.port !== want.port || got.rts !== want.rts) begin
					fault_count++;
					if (fault_count <= MAX_REPORTS)
						$display("Mismatch: expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
							want.status, want.name, want.port, want.rts,
							got.status, got.name, got.port, got.rts);
				end
			end
		end
	end

	initial begin
		int mode;
		int len;
		clear_model();

		add_row(OP_LOOKUP, 0, 0, 0, 1'b1, STAT_INVALID, 0, 0, 0);
		add_row(OP_LOOKUP, 65535, 511, 7, 1'b1, STAT_INVALID, 0, 0, 0);
		add_row(OP_FREE, 255, 0, 0, 1'b1, STAT_INVALID, 0, 0, 0);
		add_row(OP_FREE, 0, 0, 0, 1'b1, STAT_INVALID, 0, 0, 0);
		add_row(OP_ALLOC, 0, 0, 7, 1'b1, STAT_OK, 1, 0, 0);
		add_row(OP_LOOKUP, 1, 0, 0, 1'b0, STAT_OK, 0, 0, 0);
		add_row(OP_BIND, 0, 511, 0, 1'b1, STAT_OK, 2, 0, 0);
		add_row(OP_LOOKUP, 2, 0, 0, 1'b1, STAT_INVALID, 0, 0, 0);
		// A free on a port that never held a reference leaves its count at zero.
		add_row(OP_FREE, 2, 0, 0, 1'b1, STAT_OK, 0, 0, 0);
		add_row(OP_LOOKUP, 256, 0, 0, 1'b1, STAT_INVALID, 0, 0, 0);
		add_row(OP_ALLOC, 0, 0, 0, 1'b0, STAT_OK, 0, 0, 0);
		add_row(OP_BIND, 0, 1, 3, 1'b0, STAT_OK, 0, 0, 0);
		add_row(OP_FREE, 3, 0, 0, 1'b0, STAT_OK, 0, 0, 0);
		add_row(OP_LOOKUP, 4, 0, 0, 1'b0, STAT_OK, 0, 0, 0);
		add_row(OP_ALLOC, 0, 0, 4, 1'b0, STAT_OK, 0, 0, 0);
		add_row(OP_LOOKUP, 4, 0, 0, 1'b0, STAT_OK, 0, 0, 0);
		add_row(OP_FREE, 1, 0, 0, 1'b0, STAT_OK, 0, 0, 0);
		add_row(OP_FREE, 1, 0, 0, 1'b0, STAT_OK, 0, 0, 0);
		add_row(OP_BIND, 0, 0, 5, 1'b0, STAT_OK, 0, 0, 0);
		add_row(OP_LOOKUP, 6, 0, 0, 1'b0, STAT_OK, 0, 0, 0);
		add_row(OP_LOOKUP, 65280, 0, 0, 1'b1, STAT_INVALID, 0, 0, 0);
		add_row(OP_BIND, 0, 256, 6, 1'b0, STAT_OK, 0, 0, 0);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i])
			send_item(plan[i].code, plan[i].name, plan[i].slot, plan[i].rts,
				plan[i].typed, plan[i].want);

		// The first phase binds more names than the table holds, so it wraps the
		// hint and runs into a full table on both allocate and bind.
		sent_count = 0;
		while (sent_count < FILL_ITEMS)
			random_item(MODE_FILL);
		while (sent_count < RANDOM_ITEMS) begin
			mode = $urandom_range(MODE_FILL, MODE_MIX);
			len = $urandom_range(100, 250);
			if (len > RANDOM_ITEMS - sent_count)
				len = RANDOM_ITEMS - sent_count;
			repeat (len) random_item(mode);
		end
		req_valid <= 1'b0;

		while (replies_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fault_count == 0)
			$display("[port_name_table_allocator] OK");
		else
			$display("[port_name_table_allocator] ERROR");
		$finish;
	end

endmodule

// File: port_name_table_allocator.f
hw/rtl/pnta_pkg.sv
hw/rtl/pnta_ram.sv
hw/rtl/pnta_name_map.sv
hw/rtl/pnta_port_pool.sv
hw/rtl/port_name_table_allocator.sv
tb/tb_port_name_table_allocator.sv
